// ===== rtl/text_terminal_cell_writer_top_macros.svh =====
// assertion macros used by the checker file of the console cell writer
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef TEXT_TERMINAL_CELL_WRITER_TOP_MACROS_SVH
`define TEXT_TERMINAL_CELL_WRITER_TOP_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define TTCW_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TTCW_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttcw_pkg.sv =====
// shared types and constants of the console cell writer
// no dependencies; used by the top level and the checker
`default_nettype none

package ttcw_pkg;

  // default grid size
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // control bytes
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // tab stops
  localparam int TAB_STEP = 4;
  localparam int TAB_BITS = $clog2(TAB_STEP);
  localparam int CNT_W    = $clog2(TAB_STEP + 1);

  // item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_WRITE,
    S_CLEAR,
    S_RDWAIT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ttcw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ttcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_cell_writer_top.sv =====
// Console cell writer: one item at a time; reset is synchronous. A read waits on the
// registered ram read; an off-grid cell or a row not written since reset, form feed
// or scroll reads as space with no ram access. Newline and form feed go straight to
// the result; backspace writes a space, none at column 0; a printable put takes any
// deferred wrap, then writes; tab writes up to 4 spaces; a stalled result holds. The
// first write to such a row sweeps it to spaces through the single ram write port.
`default_nettype none

module text_terminal_cell_writer_top #(
  parameter int ROWS = ttcw_pkg::ROWS_DEF,
  parameter int COLS = ttcw_pkg::COLS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire ttcw_pkg::cmd_item_t cmd,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output ttcw_pkg::rsp_item_t      rsp
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int CXW = $clog2(COLS + 1);
  localparam int AW  = $clog2(ROWS * COLS);
  localparam int CNW = ttcw_pkg::CNT_W;

  // control state
  ttcw_pkg::state_t state, state_next;
  logic [CXW-1:0]   cx, cx_next;
  logic [RW-1:0]    cy, cy_next;
  logic [RW-1:0]    top, top_next;
  logic [ROWS-1:0]  row_valid, row_valid_next;

  // per-item working registers
  logic [CNW-1:0]   cnt, cnt_next;
  logic [7:0]       wchar, wchar_next;
  logic             adv, adv_next;
  logic [CW-1:0]    clr_col, clr_col_next;
  logic [7:0]       rd_char, rd_char_next;
  logic             load;

  // address path
  logic [RW-1:0]    lrow;
  logic [RW:0]      psum;
  logic [RW-1:0]    prow;
  logic [CW-1:0]    acol;
  logic [AW-1:0]    addr;
  logic [RW-1:0]    top_inc;
  logic             in_range;

  // ram port
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign cmd_stall = (state != ttcw_pkg::S_IDLE);

  // logical row to physical row through the scroll pointer, then cell address
  always_comb begin
    lrow = (state == ttcw_pkg::S_IDLE) ? RW'(cmd.read_row) : cy;
    psum = {1'b0, lrow} + {1'b0, top};
    prow = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : RW'(psum);
    case (state)
      ttcw_pkg::S_IDLE:  acol = CW'(cmd.read_col);
      ttcw_pkg::S_CLEAR: acol = clr_col;
      default:           acol = CW'(cx);
    endcase
    addr = AW'(prow) * AW'(COLS) + AW'(acol);
  end

  assign top_inc  = (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
  assign in_range = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLS);

  ttcw_ram #(
    .WIDTH (8),
    .DEPTH (ROWS * COLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // state register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttcw_pkg::S_IDLE;
      cx        <= '0;
      cy        <= '0;
      top       <= '0;
      row_valid <= '0;
    end else begin
      state     <= state_next;
      cx        <= cx_next;
      cy        <= cy_next;
      top       <= top_next;
      row_valid <= row_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    wchar   <= wchar_next;
    adv     <= adv_next;
    clr_col <= clr_col_next;
    rd_char <= rd_char_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.cell_char  <= rd_char;
      rsp.cursor_col <= 7'(cx);
      rsp.cursor_row <= 5'(cy);
    end
  end

  // sequencer: next state, cursor and ram accesses
  always_comb begin
    state_next     = state;
    cx_next        = cx;
    cy_next        = cy;
    top_next       = top;
    row_valid_next = row_valid;
    cnt_next       = cnt;
    wchar_next     = wchar;
    adv_next       = adv;
    clr_col_next   = clr_col;
    rd_char_next   = rd_char;
    ram_we         = 1'b0;
    ram_wdata      = wchar;
    ram_re         = 1'b0;
    load           = 1'b0;
    case (state)
      ttcw_pkg::S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == ttcw_pkg::KIND_READ) begin
            // untouched rows and cells off the grid read as space
            if (in_range && row_valid[prow]) begin
              ram_re     = 1'b1;
              state_next = ttcw_pkg::S_RDWAIT;
            end else begin
              rd_char_next = ttcw_pkg::CH_SPACE;
              state_next   = ttcw_pkg::S_RESP;
            end
          end else begin
            rd_char_next = '0;
            case (cmd.char_code)
              ttcw_pkg::CH_FF: begin
                row_valid_next = '0;
                top_next       = '0;
                cx_next        = '0;
                cy_next        = '0;
                state_next     = ttcw_pkg::S_RESP;
              end
              ttcw_pkg::CH_LF, ttcw_pkg::CH_CR: begin
                cx_next = '0;
                if (cy == RW'(ROWS - 1)) begin
                  top_next            = top_inc;
                  row_valid_next[top] = 1'b0;
                end else begin
                  cy_next = cy + RW'(1);
                end
                state_next = ttcw_pkg::S_RESP;
              end
              ttcw_pkg::CH_BS: begin
                if (cx != '0) begin
                  cx_next    = cx - CXW'(1);
                  wchar_next = ttcw_pkg::CH_SPACE;
                  adv_next   = 1'b0;
                  state_next = ttcw_pkg::S_WRITE;
                end else begin
                  state_next = ttcw_pkg::S_RESP;
                end
              end
              ttcw_pkg::CH_TAB: begin
                cnt_next   = CNW'(ttcw_pkg::TAB_STEP) - CNW'(cx[ttcw_pkg::TAB_BITS-1:0]);
                wchar_next = ttcw_pkg::CH_SPACE;
                adv_next   = 1'b1;
                state_next = ttcw_pkg::S_EMIT;
              end
              default: begin
                cnt_next   = CNW'(1);
                wchar_next = cmd.char_code;
                adv_next   = 1'b1;
                state_next = ttcw_pkg::S_EMIT;
              end
            endcase
          end
        end
      end
      ttcw_pkg::S_EMIT: begin
        // deferred wrap, scrolling from the bottom row
        if (cx == CXW'(COLS)) begin
          cx_next = '0;
          if (cy == RW'(ROWS - 1)) begin
            top_next            = top_inc;
            row_valid_next[top] = 1'b0;
          end else begin
            cy_next = cy + RW'(1);
          end
        end else begin
          state_next = ttcw_pkg::S_WRITE;
        end
      end
      ttcw_pkg::S_WRITE: begin
        if (!row_valid[prow]) begin
          clr_col_next = '0;
          state_next   = ttcw_pkg::S_CLEAR;
        end else begin
          ram_we = 1'b1;
          if (adv) begin
            cx_next    = cx + CXW'(1);
            cnt_next   = cnt - CNW'(1);
            state_next = (cnt == CNW'(1)) ? ttcw_pkg::S_RESP : ttcw_pkg::S_EMIT;
          end else begin
            state_next = ttcw_pkg::S_RESP;
          end
        end
      end
      ttcw_pkg::S_CLEAR: begin
        // blank the row before its first write
        ram_we       = 1'b1;
        ram_wdata    = ttcw_pkg::CH_SPACE;
        clr_col_next = clr_col + CW'(1);
        if (clr_col == CW'(COLS - 1)) begin
          row_valid_next[prow] = 1'b1;
          state_next           = ttcw_pkg::S_WRITE;
        end
      end
      ttcw_pkg::S_RDWAIT: begin
        rd_char_next = ram_rdata;
        state_next   = ttcw_pkg::S_RESP;
      end
      ttcw_pkg::S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = ttcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ttcw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ttcw_checker.sv =====
// port-level checker for the console cell writer, bound to the top level
// depends on ttcw_pkg and text_terminal_cell_writer_top_macros.svh
`default_nettype none

`include "text_terminal_cell_writer_top_macros.svh"

module ttcw_checker #(
  parameter int ROWS = ttcw_pkg::ROWS_DEF,
  parameter int COLS = ttcw_pkg::COLS_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                cmd_valid,
  input wire logic                cmd_stall,
  input wire ttcw_pkg::cmd_item_t cmd,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire ttcw_pkg::rsp_item_t rsp
);

  // a stalled result holds
  `TTCW_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

  // one item in work at a time
  `TTCW_ASSERT_NEXT(a_one_item, clk, rst, cmd_valid && !cmd_stall, cmd_stall, "item accepted while busy")

  // cursor row stays on the grid; the column may also sit at COLS, the pending-wrap position
  `TTCW_ASSERT_NOW(a_row_range, clk, rst, rsp_valid, int'(rsp.cursor_row) < ROWS, "cursor row off grid")

  `TTCW_ASSERT_NOW(a_col_range, clk, rst, rsp_valid, int'(rsp.cursor_col) <= COLS, "cursor column off grid")

endmodule

bind text_terminal_cell_writer_top ttcw_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_ttcw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== verif/tb_text_terminal_cell_writer_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for text_terminal_cell_writer_top (console cell store)
// depends on ttcw_pkg and the top level; carries its own console predictor

module tb_text_terminal_cell_writer_top;

  localparam int ROWS         = ttcw_pkg::ROWS_DEF;
  localparam int COLS         = ttcw_pkg::COLS_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_AT      = 150;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 2 * COLS + 40;
  localparam int CMD_W        = $bits(ttcw_pkg::cmd_item_t);

  // one queued item plus a flag telling the driver to wait for a drained block
  typedef struct packed {
    logic                wait_idle;
    ttcw_pkg::cmd_item_t item;
  } pending_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  ttcw_pkg::cmd_item_t cmd       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  ttcw_pkg::rsp_item_t rsp;

  pending_t            pending_q[$];
  ttcw_pkg::rsp_item_t expected_q[$];

  // predictor state
  logic [7:0] screen_model[ROWS][COLS];
  int         cur_x;
  int         cur_y;

  int                  errors       = 0;
  int                  results_seen = 0;
  logic                calm         = 1'b0;
  int                  calm_left    = 0;
  int                  gap_left     = 0;
  int                  stall_left   = 0;
  int                  hold_left    = 0;
  logic                pause_next   = 1'b0;
  logic                drv_offer;
  pending_t            drv_next;
  ttcw_pkg::rsp_item_t mon_want;

  text_terminal_cell_writer_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_screen();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen_model[r][c] = ttcw_pkg::CH_SPACE;
  endfunction

  // top row drops out, blank row enters at the bottom
  function automatic void shift_rows_up();
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++)
        screen_model[r][c] = screen_model[r + 1][c];
    for (int c = 0; c < COLS; c++)
      screen_model[ROWS - 1][c] = ttcw_pkg::CH_SPACE;
    cur_y = ROWS - 1;
  endfunction

  // deferred wrap first, then scroll if needed, then store
  function automatic void place_glyph(logic [7:0] ch);
    if (cur_x >= COLS) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= ROWS)
      shift_rows_up();
    screen_model[cur_y][cur_x] = ch;
    cur_x++;
  endfunction

  function automatic void apply_byte(logic [7:0] ch);
    int n;
    case (ch)
      ttcw_pkg::CH_FF: begin
        clear_screen();
        cur_x = 0;
        cur_y = 0;
      end
      ttcw_pkg::CH_LF, ttcw_pkg::CH_CR: begin
        cur_x = 0;
        cur_y++;
        if (cur_y >= ROWS)
          shift_rows_up();
      end
      ttcw_pkg::CH_BS: begin
        if (cur_x > 0) begin
          cur_x--;
          screen_model[cur_y][cur_x] = ttcw_pkg::CH_SPACE;
        end
      end
      ttcw_pkg::CH_TAB: begin
        n = ttcw_pkg::TAB_STEP - (cur_x % ttcw_pkg::TAB_STEP);
        for (int i = 0; i < n; i++)
          place_glyph(ttcw_pkg::CH_SPACE);
      end
      default: begin
        place_glyph(ch);
      end
    endcase
  endfunction

  function automatic ttcw_pkg::rsp_item_t console_result(ttcw_pkg::cmd_item_t it);
    ttcw_pkg::rsp_item_t r;
    r.cell_char = '0;
    if (it.kind == ttcw_pkg::KIND_PUT)
      apply_byte(it.char_code);
    else if (it.read_row < ROWS && it.read_col < COLS)
      r.cell_char = screen_model[it.read_row][it.read_col];
    else
      r.cell_char = ttcw_pkg::CH_SPACE;
    r.cursor_col = cur_x[6:0];
    r.cursor_row = cur_y[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // mostly no gap, some short ones, a few long ones; none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_item(ttcw_pkg::cmd_item_t it);
    pending_t p;
    p.wait_idle = pause_next;
    p.item      = it;
    pause_next  = 1'b0;
    pending_q.push_back(p);
  endfunction

  // unused fields carry random bits
  function automatic void add_put(logic [7:0] ch);
    ttcw_pkg::cmd_item_t it;
    it           = CMD_W'($urandom);
    it.kind      = ttcw_pkg::KIND_PUT;
    it.char_code = ch;
    add_item(it);
  endfunction

  function automatic void add_read(int row, int col);
    ttcw_pkg::cmd_item_t it;
    it          = CMD_W'($urandom);
    it.kind     = ttcw_pkg::KIND_READ;
    it.read_row = row[4:0];
    it.read_col = col[6:0];
    add_item(it);
  endfunction

  // any byte that the console stores as a glyph
  function automatic logic [7:0] pick_glyph();
    logic [7:0] ch;
    do
      ch = 8'($urandom_range(0, 255));
    while (ch == ttcw_pkg::CH_FF || ch == ttcw_pkg::CH_LF || ch == ttcw_pkg::CH_CR ||
           ch == ttcw_pkg::CH_BS || ch == ttcw_pkg::CH_TAB);
    return ch;
  endfunction

  function automatic logic [7:0] pick_newline();
    return $urandom_range(0, 1) ? ttcw_pkg::CH_LF : ttcw_pkg::CH_CR;
  endfunction

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- idling phases

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else begin
      // accepted item goes through the predictor
      if (cmd_valid && !cmd_stall)
        expected_q.push_back(console_result(cmd));
      drv_offer = cmd_valid && cmd_stall;
      if (!drv_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].wait_idle && expected_q.size() > 0)) begin
          drv_next = pending_q.pop_front();
          cmd <= drv_next.item;
          drv_offer = 1'b1;
          gap_left = idle_len();
        end
      end
      cmd_valid <= drv_offer;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual char %h col %0d row %0d",
                   $time, rsp.cell_char, rsp.cursor_col, rsp.cursor_row);
        end else begin
          mon_want = expected_q.pop_front();
          report_field("cell_char", mon_want.cell_char, rsp.cell_char);
          report_field("cursor_col", 8'(mon_want.cursor_col), 8'(rsp.cursor_col));
          report_field("cursor_row", 8'(mon_want.cursor_row), 8'(rsp.cursor_row));
        end
        results_seen++;
        // one long hold-off so the block backs up into its input
        if (results_seen == HOLD_AT)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        stall_left = idle_len();
        rsp_stall <= (stall_left > 0);
        if (stall_left > 0)
          stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int                  base;
    int                  seg;
    int                  pick;
    int                  len;
    ttcw_pkg::cmd_item_t noise;

    clear_screen();
    cur_x = 0;
    cur_y = 0;

    // directed: field extremes, control bytes, reads inside and outside the grid
    add_read(0, 0);
    add_read(31, 127);
    add_put(8'h41);
    add_put(8'h00);
    add_put(8'hFF);
    add_put(8'h80);
    add_read(0, 0);
    add_read(0, 3);
    add_put(ttcw_pkg::CH_TAB);
    add_put(ttcw_pkg::CH_BS);
    add_read(0, 7);
    add_put(ttcw_pkg::CH_CR);
    add_put(ttcw_pkg::CH_BS);
    add_put(ttcw_pkg::CH_LF);
    add_put(8'h7F);
    add_read(2, 0);
    pause_next = 1'b1;
    add_put(ttcw_pkg::CH_FF);
    add_read(0, 0);
    add_read(ROWS - 1, COLS - 1);
    add_read(ROWS, 0);
    add_read(0, COLS);
    add_put(ttcw_pkg::CH_SPACE);

    // random: mostly well-formed text with newlines, edges and reads
    base = pending_q.size();
    seg  = 0;
    while (pending_q.size() - base < RANDOM_ITEMS) begin
      if (seg % 40 == 0)
        pause_next = 1'b1;
      seg++;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // short line of text
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
          add_put(pick_glyph());
        if ($urandom_range(0, 1))
          add_put(pick_newline());
      end else if (pick < 48) begin
        // reads, mostly where text tends to sit
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            add_read($urandom_range(0, 31), $urandom_range(0, 127));
          else if ($urandom_range(0, 2) == 0)
            add_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
          else
            add_read($urandom_range(0, ROWS - 1), $urandom_range(0, 15));
        end
      end else if (pick < 60) begin
        // newline burst with sparse text, drives scrolling
        len = $urandom_range(3, 30);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0)
            add_put(pick_glyph());
          add_put(pick_newline());
        end
      end else if (pick < 64) begin
        // full row up to the pending wrap, then something at the edge
        add_put(ttcw_pkg::CH_CR);
        for (int i = 0; i < COLS; i++)
          add_put(pick_glyph());
        case ($urandom_range(0, 4))
          0: add_put(ttcw_pkg::CH_BS);
          1: add_put(ttcw_pkg::CH_TAB);
          2: add_put(pick_glyph());
          3: add_put(pick_newline());
          default: add_read($urandom_range(0, ROWS - 1), COLS - 1);
        endcase
        add_read($urandom_range(0, ROWS - 1), COLS - 1);
      end else if (pick < 72) begin
        // tab run, sometimes long enough to wrap
        if ($urandom_range(0, 1))
          add_put(ttcw_pkg::CH_CR);
        len = $urandom_range(1, COLS / ttcw_pkg::TAB_STEP + 2);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0)
            add_put(pick_glyph());
          add_put(ttcw_pkg::CH_TAB);
        end
      end else if (pick < 80) begin
        // backspaces, often past the start of the row
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++)
          add_put(pick_glyph());
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          add_put(ttcw_pkg::CH_BS);
      end else if (pick < 82) begin
        add_put(ttcw_pkg::CH_FF);
      end else begin
        // noise: any kind, any bits
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          noise = CMD_W'($urandom);
          add_item(noise);
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || cmd_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
